// ===== hdl/lsled_pkg.sv =====
// ----------------------------------------------------------------------------
// lsled_pkg
// Shared types, codes and constants of the layered status LED controller.
// ----------------------------------------------------------------------------
package lsled_pkg;

  localparam int unsigned DepthW   = 8;
  localparam int unsigned TimerW   = 10;
  localparam int unsigned CfgW     = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned ReqW     = 3;
  localparam int unsigned PatW     = 3;

  localparam logic [DepthW-1:0] MaxNesting = DepthW'(255);

  localparam logic [CfgW-1:0] HoldTicksRst = CfgW'(150);
  localparam logic [CfgW-1:0] FastHalfRst  = CfgW'(50);
  localparam logic [CfgW-1:0] SlowHalfRst  = CfgW'(450);

  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FAST_HALF  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLOW_HALF  = 2'd2;

  localparam logic [ReqW-1:0] REQ_TICK      = 3'd0;
  localparam logic [ReqW-1:0] REQ_BEGIN     = 3'd1;
  localparam logic [ReqW-1:0] REQ_END       = 3'd2;
  localparam logic [ReqW-1:0] REQ_SET_CONN  = 3'd3;
  localparam logic [ReqW-1:0] REQ_SET_FAULT = 3'd4;

  localparam logic [PatW-1:0] PAT_BOTH_SLOW   = 3'd0;
  localparam logic [PatW-1:0] PAT_GREEN_SOLID = 3'd1;
  localparam logic [PatW-1:0] PAT_GREEN_BLINK = 3'd2;
  localparam logic [PatW-1:0] PAT_RED_BLINK   = 3'd3;
  localparam logic [PatW-1:0] PAT_RED_SOLID   = 3'd4;

  typedef struct packed {
    logic [ReqW-1:0] req_type;
    logic            layer;
    logic            flag_value;
  } item_t;

  typedef struct packed {
    logic [CfgW-1:0] hold_ticks;
    logic [CfgW-1:0] fast_half_period;
    logic [CfgW-1:0] slow_half_period;
  } cfg_t;

  function automatic logic pat_blinks(input logic [PatW-1:0] p);
    return (p == PAT_BOTH_SLOW) || (p == PAT_GREEN_BLINK) || (p == PAT_RED_BLINK);
  endfunction

  function automatic logic [PatW-1:0] resolve(input logic fault, input logic bus_act,
                                              input logic pas_act, input logic conn);
    logic [PatW-1:0] p;
    if (fault) begin
      p = PAT_RED_SOLID;
    end else if (bus_act) begin
      p = PAT_RED_BLINK;
    end else if (pas_act) begin
      p = PAT_GREEN_BLINK;
    end else if (conn) begin
      p = PAT_GREEN_SOLID;
    end else begin
      p = PAT_BOTH_SLOW;
    end
    return p;
  endfunction

endpackage

// ===== hdl/lsled_req_if.sv =====
// ----------------------------------------------------------------------------
// lsled_req_if
// Request channel: valid/ready handshake with request type, layer and flag.
// ----------------------------------------------------------------------------
interface lsled_req_if;
  logic                       valid;
  logic                       ready;
  logic [lsled_pkg::ReqW-1:0] req_type;
  logic                       layer;
  logic                       flag_value;

  modport source (output valid, output req_type, output layer, output flag_value,
                  input ready);
  modport sink (input valid, input req_type, input layer, input flag_value,
                output ready);
endinterface

// ===== hdl/lsled_res_if.sv =====
// ----------------------------------------------------------------------------
// lsled_res_if
// Result channel: valid/ready handshake with LED drives and pattern code.
// ----------------------------------------------------------------------------
interface lsled_res_if;
  logic                       valid;
  logic                       ready;
  logic                       green_led;
  logic                       red_led;
  logic [lsled_pkg::PatW-1:0] pattern_code;

  modport source (output valid, output green_led, output red_led, output pattern_code,
                  input ready);
  modport sink (input valid, input green_led, input red_led, input pattern_code,
                output ready);
endinterface

// ===== hdl/lsled_cfg.sv =====
// ----------------------------------------------------------------------------
// lsled_cfg
// Configuration registers: hold time and the two blink half periods.
// ----------------------------------------------------------------------------
module lsled_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsled_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lsled_pkg::CfgW-1:0]    cfg_data_i,
  output lsled_pkg::cfg_t               cfg_o
);

  lsled_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ticks       <= lsled_pkg::HoldTicksRst;
      cfg_q.fast_half_period <= lsled_pkg::FastHalfRst;
      cfg_q.slow_half_period <= lsled_pkg::SlowHalfRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsled_pkg::CFG_HOLD_TICKS: cfg_q.hold_ticks       <= cfg_data_i;
        lsled_pkg::CFG_FAST_HALF:  cfg_q.fast_half_period <= cfg_data_i;
        lsled_pkg::CFG_SLOW_HALF:  cfg_q.slow_half_period <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/lsled_in_stage.sv =====
// ----------------------------------------------------------------------------
// lsled_in_stage
// Input register: captures one request word, refilled as the engine drains it.
// ----------------------------------------------------------------------------
module lsled_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  lsled_req_if.sink          req_i,
  input  logic               pop_i,
  output logic               valid_o,
  output lsled_pkg::item_t   item_o
);

  logic             valid_q;
  lsled_pkg::item_t item_q;
  logic             load;

  assign req_i.ready = !valid_q || pop_i;
  assign load        = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.req_type   <= req_i.req_type;
      item_q.layer      <= req_i.layer;
      item_q.flag_value <= req_i.flag_value;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/lsled_engine.sv =====
// ----------------------------------------------------------------------------
// lsled_engine
// Layer state, pattern resolution, blink timing and the result register.
// ----------------------------------------------------------------------------
module lsled_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsled_pkg::cfg_t    cfg_i,
  input  logic               valid_i,
  input  lsled_pkg::item_t   item_i,
  output logic               pop_o,
  lsled_res_if.source        res_o
);

  logic [lsled_pkg::DepthW-1:0] bus_depth_q, bus_depth_d;
  logic [lsled_pkg::DepthW-1:0] pas_depth_q, pas_depth_d;
  logic [lsled_pkg::TimerW-1:0] bus_hold_q, bus_hold_d;
  logic [lsled_pkg::TimerW-1:0] pas_hold_q, pas_hold_d;
  logic                         conn_q, conn_d;
  logic                         fault_q, fault_d;
  logic [lsled_pkg::PatW-1:0]   pat_q, pat_d;
  logic                         phase_q, phase_d;
  logic [lsled_pkg::TimerW-1:0] timer_q, timer_d;

  logic                         out_valid_q;
  logic                         green_q, red_q;
  logic [lsled_pkg::PatW-1:0]   out_pat_q;

  logic                         reeval;
  logic                         expire;
  logic [lsled_pkg::PatW-1:0]   new_pat;
  logic [lsled_pkg::TimerW-1:0] new_half;
  logic                         green_any, red_on;

  assign pop_o = valid_i && (!out_valid_q || res_o.ready);

  always_comb begin
    bus_depth_d = bus_depth_q;
    pas_depth_d = pas_depth_q;
    bus_hold_d  = bus_hold_q;
    pas_hold_d  = pas_hold_q;
    conn_d      = conn_q;
    fault_d     = fault_q;
    pat_d       = pat_q;
    phase_d     = phase_q;
    timer_d     = timer_q;
    reeval      = 1'b0;
    expire      = 1'b0;

    case (item_i.req_type)
      lsled_pkg::REQ_TICK: begin
        if (bus_hold_q != '0) bus_hold_d = bus_hold_q - 1'b1;
        if (pas_hold_q != '0) pas_hold_d = pas_hold_q - 1'b1;
        if (lsled_pkg::pat_blinks(pat_q)) begin
          if (timer_q > lsled_pkg::TimerW'(1)) begin
            timer_d = timer_q - 1'b1;
          end else begin
            expire = 1'b1;
          end
        end
      end
      lsled_pkg::REQ_BEGIN: begin
        if (item_i.layer) begin
          if (bus_depth_q < lsled_pkg::MaxNesting) begin
            bus_depth_d = bus_depth_q + 1'b1;
            reeval      = (bus_depth_q == '0);
          end
        end else begin
          if (pas_depth_q < lsled_pkg::MaxNesting) begin
            pas_depth_d = pas_depth_q + 1'b1;
            reeval      = (pas_depth_q == '0);
          end
        end
      end
      lsled_pkg::REQ_END: begin
        if (item_i.layer) begin
          if (bus_depth_q != '0) begin
            bus_hold_d  = cfg_i.hold_ticks;
            bus_depth_d = bus_depth_q - 1'b1;
            reeval      = (bus_depth_q == lsled_pkg::DepthW'(1));
          end
        end else begin
          if (pas_depth_q != '0) begin
            pas_hold_d  = cfg_i.hold_ticks;
            pas_depth_d = pas_depth_q - 1'b1;
            reeval      = (pas_depth_q == lsled_pkg::DepthW'(1));
          end
        end
      end
      lsled_pkg::REQ_SET_CONN: begin
        conn_d = item_i.flag_value;
        reeval = (conn_q != item_i.flag_value);
      end
      lsled_pkg::REQ_SET_FAULT: begin
        fault_d = item_i.flag_value;
        reeval  = (fault_q != item_i.flag_value);
      end
      default: ;
    endcase

    new_pat  = lsled_pkg::resolve(fault_d, (bus_depth_d != '0) || (bus_hold_d != '0),
                                  (pas_depth_d != '0) || (pas_hold_d != '0), conn_d);
    new_half = (new_pat == lsled_pkg::PAT_BOTH_SLOW) ? cfg_i.slow_half_period
                                                     : cfg_i.fast_half_period;

    if ((reeval || expire) && (new_pat != pat_q)) begin
      pat_d   = new_pat;
      phase_d = 1'b1;
      timer_d = lsled_pkg::pat_blinks(new_pat) ? new_half : '0;
    end else if (expire) begin
      phase_d = !phase_q;
      timer_d = new_half;
    end

    green_any = (pat_d == lsled_pkg::PAT_BOTH_SLOW) || (pat_d == lsled_pkg::PAT_GREEN_SOLID) ||
                (pat_d == lsled_pkg::PAT_GREEN_BLINK);
    red_on    = (pat_d == lsled_pkg::PAT_BOTH_SLOW) || (pat_d == lsled_pkg::PAT_RED_BLINK) ||
                (pat_d == lsled_pkg::PAT_RED_SOLID);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_depth_q <= '0;
      pas_depth_q <= '0;
      bus_hold_q  <= '0;
      pas_hold_q  <= '0;
      conn_q      <= 1'b0;
      fault_q     <= 1'b0;
      pat_q       <= lsled_pkg::PAT_BOTH_SLOW;
      phase_q     <= 1'b1;
      timer_q     <= lsled_pkg::SlowHalfRst;
    end else if (pop_o) begin
      bus_depth_q <= bus_depth_d;
      pas_depth_q <= pas_depth_d;
      bus_hold_q  <= bus_hold_d;
      pas_hold_q  <= pas_hold_d;
      conn_q      <= conn_d;
      fault_q     <= fault_d;
      pat_q       <= pat_d;
      phase_q     <= phase_d;
      timer_q     <= timer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      green_q   <= phase_d && green_any;
      red_q     <= phase_d && red_on;
      out_pat_q <= pat_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.green_led    = green_q;
  assign res_o.red_led      = red_q;
  assign res_o.pattern_code = out_pat_q;

endmodule

// ===== hdl/layered_status_led_controller_top.sv =====
// ----------------------------------------------------------------------------
// layered_status_led_controller_top
// Green/red status LED controller driven by prioritized fault, activity and
// connection layers with nesting depths, hold timers and blink timing.
//
//   channel   dir  handshake      payload
//   req_i     in   valid/ready    req_type[2:0], layer, flag_value
//   res_o     out  valid/ready    green_led, red_led, pattern_code[2:0]
//   cfg       in   cfg_we_i       cfg_idx_i[1:0], cfg_data_i[9:0]
//
// one word per clock while the result is not stalled; each word passes through
// the input register and then the result register. the layer state and blink
// timer update in the cycle a word moves into the result register. reset is
// asynchronous and active low, no warm-up. a stalled result holds the input
// register; one more word is taken meanwhile.
// ----------------------------------------------------------------------------
module layered_status_led_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsled_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lsled_pkg::CfgW-1:0]    cfg_data_i,
  lsled_req_if.sink                     req_i,
  lsled_res_if.source                   res_o
);

  lsled_pkg::cfg_t  cfg;
  lsled_pkg::item_t item;
  logic             item_valid;
  logic             pop;

  lsled_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lsled_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .pop_i   (pop),
    .valid_o (item_valid),
    .item_o  (item)
  );

  lsled_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (item_valid),
    .item_i  (item),
    .pop_o   (pop),
    .res_o   (res_o)
  );

  a_green_solid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.pattern_code == lsled_pkg::PAT_GREEN_SOLID)
      |-> res_o.green_led && !res_o.red_led)
    else $error("green solid pattern with wrong led drive");

  a_red_solid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.pattern_code == lsled_pkg::PAT_RED_SOLID)
      |-> res_o.red_led && !res_o.green_led)
    else $error("red solid pattern with wrong led drive");

  a_both_slow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.pattern_code == lsled_pkg::PAT_BOTH_SLOW)
      |-> res_o.red_led == res_o.green_led)
    else $error("slow blink leds out of step");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |-> !pop)
    else $error("result overwritten while stalled");

endmodule

// ===== bench/tb_layered_status_led_controller_top.sv =====
// ----------------------------------------------------------------------------
// tb_layered_status_led_controller_top
// Self-checking bench for the layered status LED controller. A behavioral
// copy of the layer stack (fault, bus, passive, connected, idle blink) with
// its nesting depths, hold counters and blink timer predicts the LED drives
// and pattern for every accepted request word; result words are compared in
// order while both channels stall at random and the timing registers move
// through zero, one, mid-range and full-scale settings.
// ----------------------------------------------------------------------------
module tb_layered_status_led_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                       green;
    logic                       red;
    logic [lsled_pkg::PatW-1:0] pat;
  } led_view_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [lsled_pkg::CfgIdxW-1:0] cfg_idx;
  logic [lsled_pkg::CfgW-1:0]    cfg_data;

  lsled_req_if req_if ();
  lsled_res_if res_if ();

  layered_status_led_controller_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predicted layer state
  logic [lsled_pkg::DepthW-1:0] bus_nest, pas_nest;
  logic [lsled_pkg::TimerW-1:0] bus_linger, pas_linger, blink_cnt;
  logic                         conn_on, fault_on, lit;
  logic [lsled_pkg::PatW-1:0]   shown;
  logic [lsled_pkg::CfgW-1:0]   cfg_hold, cfg_fast, cfg_slow;

  led_view_t pending_leds[$];
  int        mismatches = 0;
  bit        req_up = 1'b0;
  bit        calm = 1'b0;

  function automatic logic blinking(input logic [lsled_pkg::PatW-1:0] p);
    case (p)
      lsled_pkg::PAT_BOTH_SLOW, lsled_pkg::PAT_GREEN_BLINK,
      lsled_pkg::PAT_RED_BLINK: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [lsled_pkg::TimerW-1:0] half_for(
    input logic [lsled_pkg::PatW-1:0] p);
    return (p == lsled_pkg::PAT_BOTH_SLOW) ? cfg_slow : cfg_fast;
  endfunction

  // weakest layer first, stronger layers override
  function automatic logic [lsled_pkg::PatW-1:0] top_layer();
    logic [lsled_pkg::PatW-1:0] p;
    p = conn_on ? lsled_pkg::PAT_GREEN_SOLID : lsled_pkg::PAT_BOTH_SLOW;
    if (pas_nest != 0 || pas_linger != 0) p = lsled_pkg::PAT_GREEN_BLINK;
    if (bus_nest != 0 || bus_linger != 0) p = lsled_pkg::PAT_RED_BLINK;
    if (fault_on) p = lsled_pkg::PAT_RED_SOLID;
    return p;
  endfunction

  function automatic void show(input logic [lsled_pkg::PatW-1:0] p);
    shown = p;
    lit = 1'b1;
    blink_cnt = blinking(p) ? half_for(p) : '0;
  endfunction

  function automatic void refresh();
    logic [lsled_pkg::PatW-1:0] p;
    p = top_layer();
    if (p != shown) show(p);
  endfunction

  function automatic led_view_t advance_leds(input lsled_pkg::item_t w);
    led_view_t                  v;
    logic [lsled_pkg::PatW-1:0] p;
    case (w.req_type)
      lsled_pkg::REQ_TICK: begin
        if (bus_linger != 0) bus_linger--;
        if (pas_linger != 0) pas_linger--;
        if (blinking(shown)) begin
          if (blink_cnt > 1) begin
            blink_cnt--;
          end else begin
            p = top_layer();
            if (p != shown) begin
              show(p);
            end else begin
              lit = !lit;
              blink_cnt = half_for(p);
            end
          end
        end
      end
      lsled_pkg::REQ_BEGIN: begin
        if (w.layer) begin
          if (bus_nest < lsled_pkg::MaxNesting) begin
            bus_nest++;
            if (bus_nest == 1) refresh();
          end
        end else begin
          if (pas_nest < lsled_pkg::MaxNesting) begin
            pas_nest++;
            if (pas_nest == 1) refresh();
          end
        end
      end
      lsled_pkg::REQ_END: begin
        if (w.layer) begin
          if (bus_nest != 0) begin
            bus_linger = cfg_hold;
            bus_nest--;
            if (bus_nest == 0) refresh();
          end
        end else begin
          if (pas_nest != 0) begin
            pas_linger = cfg_hold;
            pas_nest--;
            if (pas_nest == 0) refresh();
          end
        end
      end
      lsled_pkg::REQ_SET_CONN: begin
        if (conn_on != w.flag_value) begin
          conn_on = w.flag_value;
          refresh();
        end
      end
      lsled_pkg::REQ_SET_FAULT: begin
        if (fault_on != w.flag_value) begin
          fault_on = w.flag_value;
          refresh();
        end
      end
      default: ;
    endcase
    v.green = lit && (shown == lsled_pkg::PAT_BOTH_SLOW ||
                      shown == lsled_pkg::PAT_GREEN_SOLID ||
                      shown == lsled_pkg::PAT_GREEN_BLINK);
    v.red   = lit && (shown == lsled_pkg::PAT_BOTH_SLOW ||
                      shown == lsled_pkg::PAT_RED_BLINK ||
                      shown == lsled_pkg::PAT_RED_SOLID);
    v.pat   = shown;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic lsled_pkg::item_t req_word(input logic [lsled_pkg::ReqW-1:0] kind,
                                                input logic lyr, input logic flag);
    lsled_pkg::item_t w;
    w.req_type   = kind;
    w.layer      = lyr;
    w.flag_value = flag;
    return w;
  endfunction

  function automatic lsled_pkg::item_t random_word();
    lsled_pkg::item_t w;
    int               r;
    r = $urandom_range(99);
    w.layer      = 1'($urandom_range(1));
    w.flag_value = 1'($urandom_range(1));
    if (r < 45) begin
      w.req_type = lsled_pkg::REQ_TICK;
    end else if (r < 67) begin
      w.req_type = lsled_pkg::REQ_BEGIN;
    end else if (r < 89) begin
      w.req_type = lsled_pkg::REQ_END;
    end else if (r < 94) begin
      w.req_type = lsled_pkg::REQ_SET_CONN;
    end else if (r < 97) begin
      w.req_type   = lsled_pkg::REQ_SET_FAULT;
      w.flag_value = ($urandom_range(2) == 0);
    end else begin
      w.req_type = lsled_pkg::REQ_SET_FAULT + lsled_pkg::ReqW'($urandom_range(3, 1));
    end
    return w;
  endfunction

  task automatic drop_req();
    if (req_up) begin
      req_if.valid <= 1'b0;
      req_up = 1'b0;
    end
  endtask

  task automatic send_word(input lsled_pkg::item_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      drop_req();
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= w.req_type;
    req_if.layer      <= w.layer;
    req_if.flag_value <= w.flag_value;
    req_up = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    pending_leds.push_back(advance_leds(w));
  endtask

  task automatic wait_drain();
    drop_req();
    do @(posedge clk_i); while (pending_leds.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lsled_pkg::CfgIdxW-1:0] idx,
                           input logic [lsled_pkg::CfgW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      lsled_pkg::CFG_HOLD_TICKS: cfg_hold = data;
      lsled_pkg::CFG_FAST_HALF:  cfg_fast = data;
      lsled_pkg::CFG_SLOW_HALF:  cfg_slow = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [lsled_pkg::CfgW-1:0] hold,
                            input logic [lsled_pkg::CfgW-1:0] fast,
                            input logic [lsled_pkg::CfgW-1:0] slow);
    wait_drain();
    write_reg(lsled_pkg::CFG_HOLD_TICKS, hold);
    write_reg(lsled_pkg::CFG_FAST_HALF, fast);
    write_reg(lsled_pkg::CFG_SLOW_HALF, slow);
  endtask

  task automatic random_burst(input int n);
    repeat (n) begin
      send_word(random_word());
      if ($urandom_range(199) == 0) wait_drain();
    end
  endtask

  // reset timing: nesting, holds, fault override, no-change sets, unknown codes
  task automatic test_directed();
    send_word(req_word(lsled_pkg::REQ_TICK, 1'b0, 1'b0));
    send_word(req_word(lsled_pkg::REQ_SET_CONN, 1'b0, 1'b1));
    send_word(req_word(lsled_pkg::REQ_SET_CONN, 1'b1, 1'b1));
    send_word(req_word(lsled_pkg::REQ_BEGIN, 1'b0, 1'b0));
    send_word(req_word(lsled_pkg::REQ_BEGIN, 1'b1, 1'b1));
    send_word(req_word(lsled_pkg::REQ_BEGIN, 1'b1, 1'b0));
    send_word(req_word(lsled_pkg::REQ_END, 1'b1, 1'b0));
    send_word(req_word(lsled_pkg::REQ_END, 1'b1, 1'b1));
    send_word(req_word(lsled_pkg::REQ_END, 1'b1, 1'b0));
    send_word(req_word(lsled_pkg::REQ_TICK, 1'b1, 1'b1));
    send_word(req_word(lsled_pkg::REQ_SET_FAULT, 1'b0, 1'b1));
    send_word(req_word(lsled_pkg::REQ_TICK, 1'b0, 1'b0));
    send_word(req_word(lsled_pkg::REQ_SET_FAULT, 1'b1, 1'b1));
    send_word(req_word(lsled_pkg::REQ_SET_FAULT + lsled_pkg::ReqW'(1), 1'b1, 1'b1));
    send_word(req_word(lsled_pkg::REQ_SET_FAULT + lsled_pkg::ReqW'(2), 1'b0, 1'b0));
    send_word(req_word(lsled_pkg::REQ_SET_FAULT + lsled_pkg::ReqW'(3), 1'b1, 1'b0));
    send_word(req_word(lsled_pkg::REQ_SET_FAULT, 1'b0, 1'b0));
    send_word(req_word(lsled_pkg::REQ_END, 1'b0, 1'b1));
    send_word(req_word(lsled_pkg::REQ_END, 1'b0, 1'b0));
    send_word(req_word(lsled_pkg::REQ_SET_CONN, 1'b0, 1'b0));
    send_word(req_word(lsled_pkg::REQ_SET_FAULT, 1'b1, 1'b0));
    send_word(req_word(lsled_pkg::REQ_TICK, 1'b0, 1'b1));
  endtask

  // zero, one and full-scale register values, plus a write to a missing index
  task automatic test_register_extremes();
    set_timing('0, '0, '0);
    write_reg(lsled_pkg::CFG_SLOW_HALF + lsled_pkg::CfgIdxW'(1), '1);
    send_word(req_word(lsled_pkg::REQ_BEGIN, 1'b0, 1'b0));
    send_word(req_word(lsled_pkg::REQ_END, 1'b0, 1'b0));
    repeat (4) send_word(req_word(lsled_pkg::REQ_TICK, 1'b0, 1'b0));
    send_word(req_word(lsled_pkg::REQ_BEGIN, 1'b1, 1'b0));
    repeat (3) send_word(req_word(lsled_pkg::REQ_TICK, 1'b1, 1'b0));
    send_word(req_word(lsled_pkg::REQ_END, 1'b1, 1'b0));
    repeat (3) send_word(req_word(lsled_pkg::REQ_TICK, 1'b1, 1'b1));
    random_burst(80);
    set_timing('1, '1, '1);
    random_burst(150);
    set_timing(lsled_pkg::CfgW'(1), lsled_pkg::CfgW'(1), lsled_pkg::CfgW'(1));
    random_burst(150);
    set_timing(lsled_pkg::CfgW'(20), lsled_pkg::CfgW'(3), lsled_pkg::CfgW'(5));
    random_burst(100);
  endtask

  // depth saturates at the nesting limit, then unwinds to zero and extra ends are ignored
  task automatic test_nesting_limit();
    set_timing(lsled_pkg::CfgW'(2), lsled_pkg::CfgW'(4), lsled_pkg::CfgW'(6));
    for (int l = 1; l >= 0; l--) begin
      repeat (int'(lsled_pkg::MaxNesting) + 3)
        send_word(req_word(lsled_pkg::REQ_BEGIN, l[0], 1'b0));
      send_word(req_word(lsled_pkg::REQ_TICK, 1'b0, 1'b0));
      repeat (int'(lsled_pkg::MaxNesting) + 3)
        send_word(req_word(lsled_pkg::REQ_END, l[0], 1'b1));
      repeat (4) send_word(req_word(lsled_pkg::REQ_TICK, 1'b0, 1'b0));
    end
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 6) begin
        set_timing(lsled_pkg::CfgW'($urandom_range(1023)),
                   lsled_pkg::CfgW'($urandom_range(1023)),
                   lsled_pkg::CfgW'($urandom_range(1023)));
      end else begin
        set_timing(lsled_pkg::CfgW'($urandom_range(40)),
                   lsled_pkg::CfgW'($urandom_range(12)),
                   lsled_pkg::CfgW'($urandom_range(20)));
      end
      calm = (ph == 2 || ph == 5);
      random_burst(50);
      calm = 1'b0;
    end
  endtask

  initial begin : result_check
    int        stall;
    led_view_t want;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.ready && res_if.valid) begin
        if (pending_leds.size() == 0) begin
          $error("result word with nothing pending");
          mismatches++;
        end else begin
          want = pending_leds.pop_front();
          if (res_if.green_led !== want.green) begin
            $error("green_led expected %0b actual %0b", want.green, res_if.green_led);
            mismatches++;
          end
          if (res_if.red_led !== want.red) begin
            $error("red_led expected %0b actual %0b", want.red, res_if.red_led);
            mismatches++;
          end
          if (res_if.pattern_code !== want.pat) begin
            $error("pattern_code expected %0d actual %0d", want.pat, res_if.pattern_code);
            mismatches++;
          end
        end
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_data          <= '0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= lsled_pkg::REQ_TICK;
    req_if.layer      <= 1'b0;
    req_if.flag_value <= 1'b0;
    cfg_hold   = lsled_pkg::HoldTicksRst;
    cfg_fast   = lsled_pkg::FastHalfRst;
    cfg_slow   = lsled_pkg::SlowHalfRst;
    bus_nest   = '0;
    pas_nest   = '0;
    bus_linger = '0;
    pas_linger = '0;
    conn_on    = 1'b0;
    fault_on   = 1'b0;
    shown      = lsled_pkg::PAT_BOTH_SLOW;
    lit        = 1'b1;
    blink_cnt  = lsled_pkg::SlowHalfRst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_nesting_limit();
    test_random_traffic();
    wait_drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
